### design/ultrasonic_echo_ranger_defines.svh
// ---------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/uer_pkg.sv
// ---------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Widths, register indexes, reset values and types shared by the design.
// ---------------------------------------------------------------------------
package uer_pkg;

	localparam int WIDTH_BITS = 25;
	localparam int TRIG_BITS  = 16;
	localparam int SCALE_BITS = 16;
	localparam int DIST_BITS  = WIDTH_BITS + SCALE_BITS;
	localparam int IDX_BITS   = 3;

	localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};

	typedef enum logic [IDX_BITS-1:0] {
		REG_TRIG_HIGH = 3'd0,
		REG_TRIG_LOW  = 3'd1,
		REG_SCALE     = 3'd2,
		REG_MIN_VALID = 3'd3,
		REG_MAX_VALID = 3'd4
	} reg_idx_t;

	localparam logic [15:0]           RST_TRIG_HIGH = 16'd1;
	localparam logic [15:0]           RST_TRIG_LOW  = 16'd1000;
	localparam logic [15:0]           RST_SCALE     = 16'd38617;
	localparam logic [WIDTH_BITS-1:0] RST_MIN_VALID = WIDTH_BITS'(100);
	localparam logic [WIDTH_BITS-1:0] RST_MAX_VALID = WIDTH_BITS'(18000000);

	typedef struct packed {
		logic [15:0]           trig_high;
		logic [15:0]           trig_low;
		logic [SCALE_BITS-1:0] scale;
	} front_cfg_t;

	// What the front stage hands to the tracking stage for one tick.
	typedef struct packed {
		logic                  trigger;
		logic                  done;
		logic                  clear;
		logic [WIDTH_BITS-1:0] width;
		logic [DIST_BITS-1:0]  product;
	} front_res_t;

endpackage

### design/uer_if.sv
// ---------------------------------------------------------------------------
// Ultrasonic echo ranger channels
// Tick input channel and result output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface uer_tick_if;
	logic valid;
	logic ready;
	logic echo;
	logic enable;

	modport source (output valid, output echo, output enable, input ready);
	modport sink (input valid, input echo, input enable, output ready);
endinterface

interface uer_result_if;
	logic                           valid;
	logic                           ready;
	logic                           trigger;
	logic                           done_res;
	logic [uer_pkg::WIDTH_BITS-1:0] width_ticks;
	logic [uer_pkg::DIST_BITS-1:0]  distance;
	logic                           in_range;
	logic [uer_pkg::DIST_BITS-1:0]  near_distance;
	logic [uer_pkg::DIST_BITS-1:0]  far_distance;

	modport source (output valid, output trigger, output done_res, output width_ticks,
		output distance, output in_range, output near_distance, output far_distance,
		input ready);
	modport sink (input valid, input trigger, input done_res, input width_ticks,
		input distance, input in_range, input near_distance, input far_distance,
		output ready);
endinterface

### design/uer_front.sv
// ---------------------------------------------------------------------------
// Ultrasonic echo ranger front stage
// Edge detection, trigger generator, echo width counter and distance product.
// ---------------------------------------------------------------------------
module uer_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                echo,
	input  logic                enable,
	input  uer_pkg::front_cfg_t cfg,
	output uer_pkg::front_res_t res_s1
);

	logic                           echo_prev_q;
	logic                           enable_prev_q;
	logic [uer_pkg::WIDTH_BITS-1:0] pulse_q;
	logic [uer_pkg::WIDTH_BITS-1:0] last_width_q;
	logic [uer_pkg::TRIG_BITS-1:0]  phase_q;
	logic                           level_q;

	logic                           echo_prev_d;
	logic [uer_pkg::WIDTH_BITS-1:0] pulse_cur;
	logic [uer_pkg::WIDTH_BITS-1:0] pulse_d;
	logic [uer_pkg::WIDTH_BITS-1:0] last_width_d;
	logic [uer_pkg::TRIG_BITS-1:0]  phase_cur;
	logic [uer_pkg::TRIG_BITS-1:0]  phase_inc;
	logic [uer_pkg::TRIG_BITS-1:0]  phase_len;
	logic [uer_pkg::TRIG_BITS-1:0]  phase_d;
	logic                           level_cur;
	logic                           level_d;
	logic                           echo_was;
	logic                           trigger_d;
	logic                           done_d;
	logic                           clear_d;
	logic [uer_pkg::DIST_BITS-1:0]  product_d;

	always_comb begin
		// A rising edge of enable restarts the trigger at its high phase.
		clear_d   = enable && !enable_prev_q;
		level_cur = clear_d ? 1'b1 : level_q;
		phase_cur = clear_d ? '0 : phase_q;
		pulse_cur = clear_d ? '0 : pulse_q;
		echo_was  = echo_prev_q;

		phase_len = level_cur ? uer_pkg::TRIG_BITS'(cfg.trig_high)
			: uer_pkg::TRIG_BITS'(cfg.trig_low);
		phase_inc = phase_cur + uer_pkg::TRIG_BITS'(1);

		product_d = uer_pkg::DIST_BITS'(pulse_cur) * uer_pkg::DIST_BITS'(cfg.scale);

		trigger_d    = 1'b0;
		done_d       = 1'b0;
		level_d      = 1'b0;
		phase_d      = '0;
		pulse_d      = '0;
		echo_prev_d  = 1'b0;
		last_width_d = last_width_q;

		if (enable) begin
			trigger_d = level_cur;
			// A phase length of zero still toggles after one tick.
			if (phase_inc >= phase_len) begin
				level_d = !level_cur;
				phase_d = '0;
			end else begin
				level_d = level_cur;
				phase_d = phase_inc;
			end

			if (echo) begin
				if (!echo_was) begin
					pulse_d = uer_pkg::WIDTH_BITS'(1);
				end else if (pulse_cur != uer_pkg::WIDTH_MAX) begin
					pulse_d = pulse_cur + uer_pkg::WIDTH_BITS'(1);
				end else begin
					pulse_d = pulse_cur;
				end
			end else if (echo_was) begin
				done_d       = 1'b1;
				last_width_d = pulse_cur;
				pulse_d      = '0;
			end else begin
				pulse_d = pulse_cur;
			end
			echo_prev_d = echo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_prev_q   <= 1'b0;
			enable_prev_q <= 1'b0;
			pulse_q       <= '0;
			last_width_q  <= '0;
			phase_q       <= '0;
			level_q       <= 1'b0;
		end else if (accept) begin
			echo_prev_q   <= echo_prev_d;
			enable_prev_q <= enable;
			pulse_q       <= pulse_d;
			last_width_q  <= last_width_d;
			phase_q       <= phase_d;
			level_q       <= level_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.trigger <= trigger_d;
			res_s1.done    <= done_d;
			res_s1.clear   <= clear_d;
			res_s1.width   <= last_width_d;
			res_s1.product <= product_d;
		end
	end

endmodule

### design/ultrasonic_echo_ranger.sv
// ---------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger generation, echo pulse width measurement and distance tracking.
// ---------------------------------------------------------------------------
// Usage: every timer tick is sent as one transfer on the tick channel with
// the sampled echo level and the enable level. Each tick yields exactly one
// transfer on the result channel: the trigger level to drive for that tick,
// a done flag when an echo pulse ended, the last width, distance and range
// flag, and the session minimum and maximum distance.
// Each tick is registered in the front stage and then in the output register
// before result valid. Throughput is one tick per cycle unless the result
// receiver stalls: the front stage (edge detection, counters, 25x16 distance
// multiply) feeds the tracking stage (min/max compares). The block holds up to two ticks in flight.
// When the result receiver stalls, the finished result stays in the output
// register and one more tick is still taken into the front stage; after
// that, tick ready drops until the result is transferred.
// Reset clears all session state and loads the register defaults. The user
// must write registers through cfg_we/cfg_index/cfg_wdata only while the
// block is idle (not enforced); indexes past the last register are ignored.
// ---------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger (
	input  logic                           clk,
	input  logic                           arst_n,
	uer_tick_if.sink                       tick,
	uer_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [uer_pkg::IDX_BITS-1:0]   cfg_index,
	input  logic [uer_pkg::WIDTH_BITS-1:0] cfg_wdata
);

	logic [15:0]                    trig_high_q;
	logic [15:0]                    trig_low_q;
	logic [uer_pkg::SCALE_BITS-1:0] scale_q;
	logic [uer_pkg::WIDTH_BITS-1:0] min_valid_q;
	logic [uer_pkg::WIDTH_BITS-1:0] max_valid_q;

	uer_pkg::front_cfg_t front_cfg;
	uer_pkg::front_res_t res_s1;

	logic                           s1_valid_q;
	logic                           out_valid_q;
	logic                           advance;
	logic                           accept;
	logic                           load_s2;

	logic                           trigger_s2;
	logic                           done_s2;
	logic [uer_pkg::WIDTH_BITS-1:0] width_s2;
	logic                           in_range_s2;
	logic [uer_pkg::DIST_BITS-1:0]  last_dist_q;
	logic [uer_pkg::DIST_BITS-1:0]  least_q;
	logic [uer_pkg::DIST_BITS-1:0]  greatest_q;
	logic                           have_q;

	logic [uer_pkg::DIST_BITS-1:0]  least_d;
	logic [uer_pkg::DIST_BITS-1:0]  greatest_d;
	logic [uer_pkg::DIST_BITS-1:0]  last_dist_d;
	logic                           have_d;
	logic                           in_range_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_high_q <= uer_pkg::RST_TRIG_HIGH;
			trig_low_q  <= uer_pkg::RST_TRIG_LOW;
			scale_q     <= uer_pkg::RST_SCALE;
			min_valid_q <= uer_pkg::RST_MIN_VALID;
			max_valid_q <= uer_pkg::RST_MAX_VALID;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uer_pkg::REG_TRIG_HIGH: trig_high_q <= cfg_wdata[15:0];
				uer_pkg::REG_TRIG_LOW:  trig_low_q  <= cfg_wdata[15:0];
				uer_pkg::REG_SCALE:     scale_q     <= cfg_wdata[uer_pkg::SCALE_BITS-1:0];
				uer_pkg::REG_MIN_VALID: min_valid_q <= cfg_wdata;
				uer_pkg::REG_MAX_VALID: max_valid_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign front_cfg.trig_high = trig_high_q;
	assign front_cfg.trig_low  = trig_low_q;
	assign front_cfg.scale     = scale_q;

	// The whole pipeline moves when the output register is free or drained.
	assign advance    = !out_valid_q || result.ready;
	assign tick.ready = !s1_valid_q || advance;
	assign accept     = tick.valid && tick.ready;
	assign load_s2    = advance && s1_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	uer_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.echo   (tick.echo),
		.enable (tick.enable),
		.cfg    (front_cfg),
		.res_s1 (res_s1)
	);

	// Session tracking: a new session empties min/max before this tick's reading.
	always_comb begin
		least_d     = res_s1.clear ? '0 : least_q;
		greatest_d  = res_s1.clear ? '0 : greatest_q;
		have_d      = res_s1.clear ? 1'b0 : have_q;
		last_dist_d = last_dist_q;
		if (res_s1.done) begin
			last_dist_d = res_s1.product;
			if (!have_d) begin
				least_d    = res_s1.product;
				greatest_d = res_s1.product;
			end else begin
				if (res_s1.product < least_d) begin
					least_d = res_s1.product;
				end
				if (res_s1.product > greatest_d) begin
					greatest_d = res_s1.product;
				end
			end
			have_d = 1'b1;
		end
		in_range_d = (res_s1.width > min_valid_q) && (res_s1.width < max_valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dist_q <= '0;
			least_q     <= '0;
			greatest_q  <= '0;
			have_q      <= 1'b0;
		end else if (load_s2) begin
			last_dist_q <= last_dist_d;
			least_q     <= least_d;
			greatest_q  <= greatest_d;
			have_q      <= have_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			trigger_s2  <= res_s1.trigger;
			done_s2     <= res_s1.done;
			width_s2    <= res_s1.width;
			in_range_s2 <= in_range_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.trigger       = trigger_s2;
	assign result.done_res      = done_s2;
	assign result.width_ticks   = width_s2;
	assign result.distance      = last_dist_q;
	assign result.in_range      = in_range_s2;
	assign result.near_distance = least_q;
	assign result.far_distance  = greatest_q;

	`UER_ASSERT_SAME(a_min_le_max, 1'b1, least_q <= greatest_q,
		"session minimum distance exceeds maximum")
	`UER_ASSERT_SAME(a_done_within_bounds, out_valid_q && done_s2,
		(least_q <= last_dist_q) && (last_dist_q <= greatest_q),
		"finished reading lies outside the session bounds")
	`UER_ASSERT_SAME(a_full_stall_blocks, s1_valid_q && out_valid_q && !result.ready,
		!tick.ready, "tick taken while both stages are full and stalled")
	`UER_ASSERT_NEXT(a_no_reading_zero, !have_q && !load_s2,
		(least_q == '0) && (greatest_q == '0),
		"session bounds nonzero before any reading")

endmodule

### tb/ultrasonic_echo_ranger_tb.sv
// ---------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Sends timer ticks with echo and enable levels through the tick channel and
// checks every result transfer against a tick-level predictor of the trigger
// generator, the echo width counter, the distance product, the range flag and
// the session minimum and maximum. Registers are reprogrammed between phases
// while the block is drained; both channels stall at random.
// ---------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD       = 8;
	localparam int RESET_CYCLES     = 5;
	localparam int HOLD_CYCLES      = 40;
	localparam int DRAIN_CYCLES     = 4;
	localparam int CYCLE_LIMIT      = 300000;
	localparam int REPORT_LIMIT     = 100;
	localparam int WB               = uer_pkg::WIDTH_BITS;
	localparam int DW               = uer_pkg::DIST_BITS;
	localparam int IB               = uer_pkg::IDX_BITS;
	localparam int IDX_FIRST_UNUSED = int'(uer_pkg::REG_MAX_VALID) + 1;
	localparam int IDX_LAST         = (1 << IB) - 1;

	typedef struct {
		logic          trigger;
		logic          done_res;
		logic [WB-1:0] width_ticks;
		logic [DW-1:0] distance;
		logic          in_range;
		logic [DW-1:0] near_distance;
		logic [DW-1:0] far_distance;
	} range_result_t;

	class echo_range_predictor;
		bit [15:0]           high_len, low_len, scale;
		bit [WB-1:0]         lim_lo, lim_hi;

		bit                  echo_q, en_q, seen_q, trig_q;
		bit [uer_pkg::TRIG_BITS-1:0] phase_cnt;
		bit [WB-1:0]         pulse_cnt, width_q;
		bit [DW-1:0]         dist_q, least_q, greatest_q;

		range_result_t       pending_results[$];
		int                  errors;

		function new();
			high_len = uer_pkg::RST_TRIG_HIGH;
			low_len  = uer_pkg::RST_TRIG_LOW;
			scale    = uer_pkg::RST_SCALE;
			lim_lo   = uer_pkg::RST_MIN_VALID;
			lim_hi   = uer_pkg::RST_MAX_VALID;
		endfunction

		function void write_reg(logic [IB-1:0] idx, logic [WB-1:0] data);
			case (idx)
				uer_pkg::REG_TRIG_HIGH: high_len = data[15:0];
				uer_pkg::REG_TRIG_LOW:  low_len  = data[15:0];
				uer_pkg::REG_SCALE:     scale    = data[15:0];
				uer_pkg::REG_MIN_VALID: lim_lo   = data;
				uer_pkg::REG_MAX_VALID: lim_hi   = data;
				default: ;
			endcase
		endfunction

		function void take_tick(bit echo, bit en);
			range_result_t r;
			bit [15:0]     len;
			r.trigger  = 1'b0;
			r.done_res = 1'b0;
			if (en) begin
				if (!en_q) begin
					least_q    = '0;
					greatest_q = '0;
					seen_q     = 1'b0;
					trig_q     = 1'b1;
					phase_cnt  = '0;
					pulse_cnt  = '0;
				end
				r.trigger = trig_q;
				// A phase length of zero toggles on every tick, the same as one.
				len = trig_q ? high_len : low_len;
				phase_cnt = phase_cnt + 1'b1;
				if (phase_cnt >= len) begin
					trig_q    = ~trig_q;
					phase_cnt = '0;
				end
				if (echo) begin
					if (!echo_q)
						pulse_cnt = WB'(1);
					else if (pulse_cnt != uer_pkg::WIDTH_MAX)
						pulse_cnt = pulse_cnt + 1'b1;
				end else if (echo_q) begin
					r.done_res = 1'b1;
					width_q = pulse_cnt;
					dist_q = DW'(width_q) * DW'(scale);
					if (!seen_q) begin
						least_q    = dist_q;
						greatest_q = dist_q;
						seen_q     = 1'b1;
					end else begin
						if (dist_q < least_q)    least_q    = dist_q;
						if (dist_q > greatest_q) greatest_q = dist_q;
					end
					pulse_cnt = '0;
				end
				echo_q = echo;
			end else begin
				// Disabled: any pulse in progress is dropped, readings are held.
				echo_q    = 1'b0;
				pulse_cnt = '0;
				trig_q    = 1'b0;
				phase_cnt = '0;
			end
			en_q = en;
			r.width_ticks   = width_q;
			r.distance      = dist_q;
			r.in_range      = (width_q > lim_lo) && (width_q < lim_hi);
			r.near_distance = least_q;
			r.far_distance  = greatest_q;
			pending_results.push_back(r);
		endfunction

		function void check_field(string name, logic [DW-1:0] want,
			logic [DW-1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t: %s mismatch, expected %0h, actual %0h",
						$time, name, want, got);
			end
		endfunction

		function void match_result(range_result_t got);
			range_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result transfer with nothing expected, expected none, actual %0h",
					$time, got.width_ticks);
				return;
			end
			want = pending_results.pop_front();
			check_field("trigger", DW'(want.trigger), DW'(got.trigger));
			check_field("done_res", DW'(want.done_res), DW'(got.done_res));
			check_field("width_ticks", DW'(want.width_ticks), DW'(got.width_ticks));
			check_field("distance", want.distance, got.distance);
			check_field("in_range", DW'(want.in_range), DW'(got.in_range));
			check_field("near_distance", want.near_distance, got.near_distance);
			check_field("far_distance", want.far_distance, got.far_distance);
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_we;
	logic [IB-1:0] cfg_index;
	logic [WB-1:0] cfg_wdata;

	uer_tick_if   tick_ch ();
	uer_result_if res_ch ();

	ultrasonic_echo_ranger uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	echo_range_predictor book = new();

	int unsigned cycle_count = 0;
	int          sent = 0;
	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Everything is sampled at the edge, before the drivers' updates land.
	always @(posedge clk) begin
		range_result_t got;
		if (arst_n === 1'b1) begin
			if (cfg_we)
				book.write_reg(cfg_index, cfg_wdata);
			if (tick_ch.valid && tick_ch.ready)
				book.take_tick(tick_ch.echo, tick_ch.enable);
			if (res_ch.valid === 1'b1 && res_ch.ready) begin
				got.trigger       = res_ch.trigger;
				got.done_res      = res_ch.done_res;
				got.width_ticks   = res_ch.width_ticks;
				got.distance      = res_ch.distance;
				got.in_range      = res_ch.in_range;
				got.near_distance = res_ch.near_distance;
				got.far_distance  = res_ch.far_distance;
				book.match_result(got);
			end
		end
	end

	// Result receiver: random short stalls, plus one long hold-off on request.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_tick(input bit echo, input bit en);
		tick_ch.valid  <= 1'b1;
		tick_ch.echo   <= echo;
		tick_ch.enable <= en;
		do @(posedge clk); while (!tick_ch.ready);
		sent++;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// One edge first so the monitor has booked the last accepted tick.
	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (book.pending_results.size() != 0) @(posedge clk);
	endtask

	// Leaves the write enable high so back-to-back writes need no lowering.
	task automatic write_reg(input logic [IB-1:0] idx,
		input logic [WB-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Programs every register; the 16-bit ones get junk in the unused bits.
	task automatic set_cfg(input int unsigned hi, input int unsigned lo,
		input int unsigned sc, input int unsigned mn, input int unsigned mx);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(uer_pkg::REG_TRIG_HIGH, {9'($urandom), 16'(hi)});
		write_reg(uer_pkg::REG_TRIG_LOW, {9'($urandom), 16'(lo)});
		write_reg(uer_pkg::REG_SCALE, {9'($urandom), 16'(sc)});
		write_reg(uer_pkg::REG_MIN_VALID, WB'(mn));
		write_reg(uer_pkg::REG_MAX_VALID, WB'(mx));
		write_reg(IB'($urandom_range(IDX_FIRST_UNUSED, IDX_LAST)),
			WB'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic pulse(input int n);
		repeat (n) send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
	endtask

	// Mostly clean echo pulses while enabled, with disabled stretches and noise.
	task automatic run_random(input int n_items);
		int stop;
		int kind;
		int len;
		stop = sent + n_items;
		while (sent < stop) begin
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'b1);
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150) :
					$urandom_range(1, 12);
				pulse(len);
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 4)) send_tick(1'($urandom), 1'b0);
			end else begin
				repeat ($urandom_range(1, 6)) send_tick(1'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		tick_ch.valid  <= 1'b0;
		tick_ch.echo   <= 1'b0;
		tick_ch.enable <= 1'b0;
		res_ch.ready   <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: disabled ticks, then enabling into a high echo.
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);

		// Zero-length high phase, narrow window so widths land on both limits.
		set_cfg(0, 2, 65535, 2, 5);
		send_tick(1'b0, 1'b1);
		pulse(2);
		pulse(3);
		pulse(5);
		pulse(1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		pulse(4);

		set_cfg(1, 1, 38617, 100, 18000000);
		run_random(60);
		hold_req = 1'b1;
		run_random(30);
		// Let the block run completely dry with no new transfer offered.
		wait_drained();
		run_random(30);

		set_cfg(65535, 65535, 0, 0, 0);
		run_random(110);

		set_cfg(0, 0, 1, 0, (1 << WB) - 1);
		run_random(110);

		set_cfg(2, 7, 65535, (1 << WB) - 1, (1 << WB) - 1);
		run_random(110);

		set_cfg($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 65535),
			$urandom_range(0, 40), $urandom_range(0, 80));
		run_random(110);

		gaps_on = 1'b0;
		set_cfg($urandom_range(1, 5), $urandom_range(1, 20), $urandom_range(0, 65535),
			$urandom_range(0, 10), $urandom_range(5, 60));
		run_random(120);

		wait_drained();
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		if (book.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
